@@ sv/bwtg_pkg.sv @@
// ----------------------------------------------------------------------------
// bwtg_pkg
// Shared widths, codes and constants of the wavetable sample generator.
// ----------------------------------------------------------------------------
package bwtg_pkg;

   localparam int TSIZE_W    = 13;
   localparam int POS_W      = 12;
   localparam int WAVE_W     = 2;
   localparam int SAMPLE_W   = 16;
   localparam int QUO_W      = 32;
   localparam int DIV_BITS   = 2;
   localparam int DIV_STAGES = QUO_W / DIV_BITS;

   // fold, angle, square, 4 per Horner step, final product, round
   localparam int HORNER_STEPS = 5;
   localparam int SIN_LAT      = 3 + 4 * HORNER_STEPS + 2;

   localparam logic [TSIZE_W-1:0] TSIZE_RESET = 13'd2048;

   localparam logic [WAVE_W-1:0] WAVE_SINE     = 2'd0;
   localparam logic [WAVE_W-1:0] WAVE_SAW      = 2'd1;
   localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 2'd2;
   localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 2'd3;

   localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

   // Taylor divisors, innermost first
   localparam int HORNER_DIVS [HORNER_STEPS] = '{110, 72, 42, 20, 6};

   typedef logic [TSIZE_W-1:0]         tsize_type;
   typedef logic [POS_W-1:0]           pos_type;
   typedef logic [WAVE_W-1:0]          wave_type;
   typedef logic [QUO_W-1:0]           quo_type;
   typedef logic signed [SAMPLE_W-1:0] sample_type;

endpackage

@@ sv/bwtg_div.sv @@
// ----------------------------------------------------------------------------
// bwtg_div
// Pipelined restoring divider: floor(num * 2^32 / den) for num < den,
// two quotient bits per stage, plus a zero-remainder flag.
// ----------------------------------------------------------------------------
module bwtg_div
   import bwtg_pkg::*;
(
   input  logic      clock,
   input  logic      enable,
   input  pos_type   num,
   input  tsize_type den,
   output quo_type   quo,
   output logic      rem_zero
);

   tsize_type rem_ff [DIV_STAGES];
   quo_type   q_ff   [DIV_STAGES];

   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
      tsize_type             r_src;
      quo_type               q_src;
      tsize_type             r_out;
      logic [DIV_BITS-1:0]   bits;

      if (j == 0) begin : g_first
         assign r_src = TSIZE_W'(num);
         assign q_src = '0;
      end else begin : g_next
         assign r_src = rem_ff[j-1];
         assign q_src = q_ff[j-1];
      end

      always_comb begin
         logic [TSIZE_W:0] r2;
         tsize_type        r;
         r    = r_src;
         bits = '0;
         for (int b = 0; b < DIV_BITS; b++) begin
            r2 = {r, 1'b0};
            if (r2 >= {1'b0, den}) begin
               r2 = r2 - {1'b0, den};
               bits[DIV_BITS-1-b] = 1'b1;
            end
            r = r2[TSIZE_W-1:0];
         end
         r_out = r;
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[j] <= r_out;
            q_ff[j]   <= {q_src[QUO_W-DIV_BITS-1:0], bits};
         end
      end
   end

   assign quo      = q_ff[DIV_STAGES-1];
   assign rem_zero = (rem_ff[DIV_STAGES-1] == '0);

endmodule

@@ sv/bwtg_sine.sv @@
// ----------------------------------------------------------------------------
// bwtg_sine
// Sine of a Q32 cycle fraction: quadrant fold, Q30 angle, Horner series
// with constant reciprocal division, rounding to signed Q1.15.
// ----------------------------------------------------------------------------
module bwtg_sine
   import bwtg_pkg::*;
(
   input  logic       clock,
   input  logic       enable,
   input  quo_type    phase,
   output sample_type sample
);

   localparam int H_FIRST = 3;
   localparam int H_LAST  = H_FIRST + 4 * HORNER_STEPS - 1;

   // stage 0: fold
   logic [1:0]  quad0_ff;
   logic [30:0] r0_ff;
   // stage 1: angle
   logic [1:0]  quad1_ff;
   logic [30:0] x1_ff;
   // carried operands, stages 2 .. H_LAST
   logic [1:0]  cq_ff  [2:H_LAST];
   logic [30:0] cx_ff  [2:H_LAST];
   logic [31:0] cx2_ff [2:H_LAST];
   // Horner registers
   logic [31:0] a_ff   [HORNER_STEPS];
   logic [61:0] p_ff   [HORNER_STEPS];
   logic [31:0] ac_ff  [HORNER_STEPS];
   logic [29:0] qq_ff  [HORNER_STEPS];
   logic [7:0]  rm_ff  [HORNER_STEPS];
   logic [30:0] h_ff   [HORNER_STEPS];
   // final product and rounding
   logic [1:0]  qs_ff;
   logic [30:0] s_ff;
   sample_type  out_ff;

   logic [30:0] r_fold;
   logic [61:0] ang_prod;
   logic [61:0] sq_prod;
   logic [61:0] s_prod;
   logic [16:0] mag;
   logic [15:0] mag_neg;

   assign r_fold   = phase[30] ? (Q30_ONE - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
   assign ang_prod = 62'(r0_ff) * 62'(HALF_PI_Q30);
   assign sq_prod  = 62'(x1_ff) * 62'(x1_ff);

   always_ff @(posedge clock) begin
      if (enable) begin
         quad0_ff  <= phase[31:30];
         r0_ff     <= r_fold;
         quad1_ff  <= quad0_ff;
         x1_ff     <= ang_prod[60:30];
         cq_ff[2]  <= quad1_ff;
         cx_ff[2]  <= x1_ff;
         cx2_ff[2] <= sq_prod[61:30];
      end
   end

   for (genvar j = 3; j <= H_LAST; j++) begin : g_carry
      always_ff @(posedge clock) begin
         if (enable) begin
            cq_ff[j]  <= cq_ff[j-1];
            cx_ff[j]  <= cx_ff[j-1];
            cx2_ff[j] <= cx2_ff[j-1];
         end
      end
   end

   for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_horner
      localparam int          BASE  = H_FIRST + 4 * k;
      localparam logic [6:0]  DVSR  = 7'(HORNER_DIVS[k]);
      localparam logic [29:0] RECIP = 30'((64'd1 << 32) / HORNER_DIVS[k]);

      logic [30:0] h_prev;
      logic [62:0] xh_prod;
      logic [31:0] qd;
      logic [31:0] rem_full;
      logic [30:0] t;

      if (k == 0) begin : g_init
         assign h_prev = Q30_ONE;
      end else begin : g_chain
         assign h_prev = h_ff[k-1];
      end

      assign xh_prod  = 63'(cx2_ff[BASE-1]) * 63'(h_prev);
      assign qd       = 32'(p_ff[k][61:32]) * 32'(DVSR);
      assign rem_full = ac_ff[k] - qd;
      assign t        = 31'(qq_ff[k]) + 31'(rm_ff[k] >= 8'(DVSR));

      always_ff @(posedge clock) begin
         if (enable) begin
            a_ff[k]  <= xh_prod[61:30];
            p_ff[k]  <= 62'(a_ff[k]) * 62'(RECIP);
            ac_ff[k] <= a_ff[k];
            // estimate is low by at most one; remainder fixes it
            qq_ff[k] <= p_ff[k][61:32];
            rm_ff[k] <= rem_full[7:0];
            h_ff[k]  <= (t >= Q30_ONE) ? '0 : (Q30_ONE - t);
         end
      end
   end

   assign s_prod  = 62'(cx_ff[H_LAST]) * 62'(h_ff[HORNER_STEPS-1]);
   assign mag     = 17'((32'(s_ff) + 32'h0000_4000) >> 15);
   assign mag_neg = (mag > 17'h0_8000) ? 16'h8000 : (~mag[15:0] + 16'd1);

   always_ff @(posedge clock) begin
      if (enable) begin
         qs_ff <= cq_ff[H_LAST];
         s_ff  <= s_prod[60:30];
         if (qs_ff[1]) begin
            out_ff <= mag_neg;
         end else begin
            out_ff <= (mag > 17'h0_7FFF) ? 16'h7FFF : mag[15:0];
         end
      end
   end

   assign sample = out_ff;

endmodule

@@ sv/basic_waveform_table_generator.sv @@
// ----------------------------------------------------------------------------
// basic_waveform_table_generator: input register, 16 divider stages, 25 sine stages
// and output register in a row. While the spare output entry is free, throughput is
// one sample per cycle; a two-entry output buffer absorbs rsp stalls.
// Synchronous reset empties the pipeline and sets table_size to 2048.
// ----------------------------------------------------------------------------
module basic_waveform_table_generator
   import bwtg_pkg::*;
#(
   parameter int MAX_TABLE_SIZE = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [12:0] csr_wdata,     // table_size
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,     // [11:0] position, [15:12] zero
   input  logic [1:0]  req_tuser,     // [1:0] waveform
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,     // [15:0] sample
   output logic        rsp_tuser      // [0] position_error
);

   tsize_type table_size_ff;
   tsize_type table_size_in;
   logic      adv;

   // input stage
   logic      s0_vld_ff;
   wave_type  s0_wave_ff;
   logic      s0_err_ff;
   logic      s0_sq_ff;
   pos_type   s0_num_ff;
   pos_type   req_pos;
   logic      req_err;

   // side band alongside the divider
   logic      dv_vld_ff  [DIV_STAGES];
   wave_type  dv_wave_ff [DIV_STAGES];
   logic      dv_err_ff  [DIV_STAGES];
   logic      dv_sq_ff   [DIV_STAGES];

   // side band alongside the sine unit
   logic       lv_vld_ff  [SIN_LAT];
   wave_type   lv_wave_ff [SIN_LAT];
   logic       lv_err_ff  [SIN_LAT];
   sample_type lv_lin_ff  [SIN_LAT];

   quo_type    quo;
   logic       rem_zero;
   sample_type sin_sample;

   logic [32:0] saw_sum;
   logic [32:0] tri_hi_sum;
   logic [32:0] tri_ceil;
   logic [32:0] tri_lo_diff;
   logic [17:0] tri_hi;
   logic [16:0] ramp_v;
   logic [15:0] ramp_off;
   sample_type  lin;

   sample_type  pe_sample;
   logic        pe_vld;

   // output buffer
   logic        out_vld_ff, out_vld_in;
   logic        skid_vld_ff, skid_vld_in;
   sample_type  out_data_ff, skid_data_ff;
   logic        out_err_ff, skid_err_ff;
   logic        take;
   logic        load_out, load_skid, out_from_skid;

   // configuration
   always_comb begin
      table_size_in = table_size_ff;
      if (csr_we) begin
         if (int'(csr_wdata) > MAX_TABLE_SIZE) begin
            table_size_in = TSIZE_W'(MAX_TABLE_SIZE);
         end else begin
            table_size_in = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= TSIZE_RESET;
      end else begin
         table_size_ff <= table_size_in;
      end
   end

   // whole pipeline moves while the spare output entry is free
   assign adv        = ~skid_vld_ff;
   assign req_tready = adv;

   assign req_pos = req_tdata[POS_W-1:0];
   assign req_err = ({1'b0, req_pos} >= table_size_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (adv) begin
         s0_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_wave_ff <= req_tuser;
         s0_err_ff  <= req_err;
         s0_sq_ff   <= ({1'b0, req_pos} < (table_size_ff >> 1));
         // out-of-range positions divide zero to keep the remainder bounded
         s0_num_ff  <= req_err ? '0 : req_pos;
      end
   end

   bwtg_div u_div (
      .clock    (clock),
      .enable   (adv),
      .num      (s0_num_ff),
      .den      (table_size_ff),
      .quo      (quo),
      .rem_zero (rem_zero)
   );

   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_dv
      if (j == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (reset) begin
               dv_vld_ff[j] <= 1'b0;
            end else if (adv) begin
               dv_vld_ff[j] <= s0_vld_ff;
            end
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               dv_wave_ff[j] <= s0_wave_ff;
               dv_err_ff[j]  <= s0_err_ff;
               dv_sq_ff[j]   <= s0_sq_ff;
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (reset) begin
               dv_vld_ff[j] <= 1'b0;
            end else if (adv) begin
               dv_vld_ff[j] <= dv_vld_ff[j-1];
            end
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               dv_wave_ff[j] <= dv_wave_ff[j-1];
               dv_err_ff[j]  <= dv_err_ff[j-1];
               dv_sq_ff[j]   <= dv_sq_ff[j-1];
            end
         end
      end
   end

   // ramps from q = floor(2^32 * i / N): rounding is exact on q
   assign saw_sum     = {1'b0, quo} + 33'h0_0000_8000;
   assign tri_hi_sum  = {1'b0, quo} + 33'h0_0000_4000;
   assign tri_hi      = tri_hi_sum[32:15] - 18'h1_0000;
   assign tri_ceil    = {1'b0, quo} + 33'(!rem_zero);
   assign tri_lo_diff = 33'h0_8000_4000 - tri_ceil;

   always_comb begin
      if (dv_wave_ff[DIV_STAGES-1] == WAVE_SAW) begin
         ramp_v = saw_sum[32:16];
      end else if (quo[QUO_W-1]) begin
         ramp_v = tri_hi[16:0];
      end else begin
         ramp_v = tri_lo_diff[31:15];
      end
      ramp_off = (ramp_v > 17'h0_FFFF) ? 16'hFFFF : ramp_v[15:0];
      case (dv_wave_ff[DIV_STAGES-1])
         WAVE_SQUARE: lin = dv_sq_ff[DIV_STAGES-1] ? 16'h7FFF : 16'h8000;
         default:     lin = {~ramp_off[15], ramp_off[14:0]};
      endcase
   end

   bwtg_sine u_sine (
      .clock  (clock),
      .enable (adv),
      .phase  (quo),
      .sample (sin_sample)
   );

   for (genvar j = 0; j < SIN_LAT; j++) begin : g_lv
      if (j == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (reset) begin
               lv_vld_ff[j] <= 1'b0;
            end else if (adv) begin
               lv_vld_ff[j] <= dv_vld_ff[DIV_STAGES-1];
            end
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               lv_wave_ff[j] <= dv_wave_ff[DIV_STAGES-1];
               lv_err_ff[j]  <= dv_err_ff[DIV_STAGES-1];
               lv_lin_ff[j]  <= lin;
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (reset) begin
               lv_vld_ff[j] <= 1'b0;
            end else if (adv) begin
               lv_vld_ff[j] <= lv_vld_ff[j-1];
            end
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               lv_wave_ff[j] <= lv_wave_ff[j-1];
               lv_err_ff[j]  <= lv_err_ff[j-1];
               lv_lin_ff[j]  <= lv_lin_ff[j-1];
            end
         end
      end
   end

   assign pe_vld = lv_vld_ff[SIN_LAT-1];

   always_comb begin
      if (lv_err_ff[SIN_LAT-1]) begin
         pe_sample = '0;
      end else if (lv_wave_ff[SIN_LAT-1] == WAVE_SINE) begin
         pe_sample = sin_sample;
      end else begin
         pe_sample = lv_lin_ff[SIN_LAT-1];
      end
   end

   // output register plus one spare entry
   assign take = out_vld_ff & rsp_tready;

   always_comb begin
      out_vld_in    = out_vld_ff;
      skid_vld_in   = skid_vld_ff;
      load_out      = 1'b0;
      load_skid     = 1'b0;
      out_from_skid = 1'b0;
      if (skid_vld_ff) begin
         if (take) begin
            out_from_skid = 1'b1;
            skid_vld_in   = 1'b0;
         end
      end else if (pe_vld) begin
         if (!out_vld_ff || take) begin
            load_out   = 1'b1;
            out_vld_in = 1'b1;
         end else begin
            load_skid   = 1'b1;
            skid_vld_in = 1'b1;
         end
      end else if (take) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_from_skid) begin
         out_data_ff <= skid_data_ff;
         out_err_ff  <= skid_err_ff;
      end else if (load_out) begin
         out_data_ff <= pe_sample;
         out_err_ff  <= lv_err_ff[SIN_LAT-1];
      end
      if (load_skid) begin
         skid_data_ff <= pe_sample;
         skid_err_ff  <= lv_err_ff[SIN_LAT-1];
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_err_ff;

endmodule
